>>> sv/silu_rt_pkg.sv
// ----------------------------------------------------------------------------
// silu_rt_pkg
// Shared types and constants for the SiLU activation pipeline: the input and
// output words, the internal Q.30 widths and the rational tanh coefficients.
// ----------------------------------------------------------------------------
package silu_rt_pkg;

    // fraction bits of every internal value
    localparam int QF = 30;

    // sample width on both channels
    localparam int W_SAMPLE = 32;

    // internal widths, sized from the value bounds below the saturation limit
    localparam int W_HM  = 33;  // |h| below 6.0
    localparam int W_H2  = 36;  // h^2 below 36.0
    localparam int W_C   = 30;  // coefficients
    localparam int W_P1  = 24;  // first numerator horner step
    localparam int W_Q1  = 26;  // first denominator horner step
    localparam int W_P2  = 28;
    localparam int W_Q2  = 31;
    localparam int W_P   = 34;  // numerator polynomial, below 16.0
    localparam int W_Q   = 36;  // denominator polynomial, in [1.0, 64.0)
    localparam int W_NUM = 36;  // h * P
    localparam int W_M   = 30;  // normalized denominator
    localparam int W_S   = 3;   // normalizing shift
    localparam int W_Y   = 31;  // reciprocal, at most 1.0
    localparam int W_T   = 32;  // newton correction term
    localparam int W_SIG = 31;  // sigmoid, at most 1.0
    localparam int W_SD  = 32;  // seed constant width

    // largest normalizing shift, denominator leading one at bit W_Q-1
    localparam int SH_MAX = W_Q - QF;

    // |x| at or above SAT_RATIO in sample units forces tanh to +1 or -1
    localparam int SAT_RATIO = 12;

    // Q.30 unit values
    localparam logic [QF:0]     Q30_ONE = 31'h4000_0000;
    localparam logic [W_T-1:0]  Q30_TWO = 32'h8000_0000;

    // numerator P(h^2) coefficients, Q.30
    localparam logic [W_C-1:0] CP1 = 30'd137659208;
    localparam logic [W_C-1:0] CP2 = 30'd3003474;
    localparam logic [W_C-1:0] CP3 = 30'd7946;

    // denominator Q(h^2) coefficients, Q.30
    localparam logic [W_C-1:0] CQ1 = 30'd495573150;
    localparam logic [W_C-1:0] CQ2 = 30'd25028947;
    localparam logic [W_C-1:0] CQ3 = 30'd222479;

    // reciprocal seed 48/17 - 32/17 * m, Q.30
    localparam logic [W_SD-1:0] SEED_A = 32'd3031741621;
    localparam logic [W_SD-2:0] SEED_B = 31'd2021161080;

    // input word
    typedef struct packed {
        logic signed [W_SAMPLE-1:0] sample_in;
        logic                       last_sample;
    } t_in_word;

    // output word
    typedef struct packed {
        logic signed [W_SAMPLE-1:0] silu_out;
        logic                       last_out;
    } t_out_word;

endpackage

>>> sv/silu_rational_tanh.sv
// ----------------------------------------------------------------------------
// silu_rational_tanh
// SiLU activation x * sigmoid(x) on signed fixed-point samples, with tanh
// taken as a rational function and the division done by a Newton reciprocal.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_ready carries one sample word per
//   transfer; output channel o_out_valid / i_out_ready returns one result
//   word per sample, in order, with the last flag copied through.
//   The datapath is a pipeline of 9 + 2*NEWTON_STEPS register stages, at
//   most one multiply deep per stage. Throughput is one word per cycle
//   while the receiver keeps i_out_ready high; the multiplier stages are
//   fully pipelined.
//   When the receiver stalls, the output register holds its word and every
//   stage behind it keeps moving until it reaches a full stage, so empty
//   slots are squeezed out and input words are still taken while any stage
//   is empty. o_in_ready falls only once every stage holds a word.
//   Reset clears all stage valid bits; the block is stateless, so nothing
//   else needs to settle and the first word may follow right after reset.
// ----------------------------------------------------------------------------
module silu_rational_tanh
    import silu_rt_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int NEWTON_STEPS = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    // stage layout
    localparam int NSTG    = 9 + 2 * NEWTON_STEPS;
    localparam int ST_RC0  = 6;
    localparam int ST_TANH = 7 + 2 * NEWTON_STEPS;
    localparam int ST_OUT  = 8 + 2 * NEWTON_STEPS;

    // h = x/2 in Q.30 is |x| shifted left by this much
    localparam int H_SHIFT = QF - 1 - FRAC_BITS;

    // |x| threshold for |h| >= 6
    localparam logic [W_SAMPLE-1:0] SAT_X = W_SAMPLE'(SAT_RATIO) << FRAC_BITS;

    localparam logic [NSTG-1:0] STG_ALL = '1;

    typedef struct packed {
        logic                last;
        logic                neg;
        logic                sat;
        logic [W_SAMPLE-1:0] ax;
    } t_side;

    typedef struct packed {
        t_side           side;
        logic [W_HM-1:0] hm;
    } t_st0;

    typedef struct packed {
        t_side           side;
        logic [W_HM-1:0] hm;
        logic [W_H2-1:0] h2;
    } t_st1;

    typedef struct packed {
        t_side           side;
        logic [W_HM-1:0] hm;
        logic [W_H2-1:0] h2;
        logic [W_P1-1:0] p1;
        logic [W_Q1-1:0] q1;
    } t_st2;

    typedef struct packed {
        t_side           side;
        logic [W_HM-1:0] hm;
        logic [W_H2-1:0] h2;
        logic [W_P2-1:0] p2;
        logic [W_Q2-1:0] q2;
    } t_st3;

    typedef struct packed {
        t_side           side;
        logic [W_HM-1:0] hm;
        logic [W_P-1:0]  pp;
        logic [W_Q-1:0]  qq;
    } t_st4;

    typedef struct packed {
        t_side            side;
        logic [W_NUM-1:0] num;
        logic [W_Q-1:0]   qq;
        logic [W_S-1:0]   sh;
        logic [W_M-1:0]   m;
    } t_st5;

    typedef struct packed {
        t_side            side;
        logic [W_NUM-1:0] num;
        logic [W_Q-1:0]   qq;
        logic [W_Y-1:0]   y;
    } t_rcp;

    typedef struct packed {
        logic                last;
        logic                neg;
        logic [W_SAMPLE-1:0] ax;
        logic [W_SIG-1:0]    sig;
    } t_tnh;

    logic [NSTG-1:0] r_vld, n_vld, adv, vld_src;

    t_st0      r_s0, n_s0;
    t_st1      r_s1, n_s1;
    t_st2      r_s2, n_s2;
    t_st3      r_s3, n_s3;
    t_st4      r_s4, n_s4;
    t_st5      r_s5, n_s5;
    t_rcp      r_rc [NEWTON_STEPS+1];
    t_rcp      n_rc0;
    t_rcp      r_na [NEWTON_STEPS];
    logic [W_T-1:0] r_nt [NEWTON_STEPS];
    t_tnh      r_tn, n_tn;
    t_out_word r_out, n_out;

    // products
    logic [2*W_HM-1:0]       prod_h2;
    logic [W_C+W_H2-1:0]     prod_p1, prod_q1;
    logic [W_P1+W_H2-1:0]    prod_p2;
    logic [W_Q1+W_H2-1:0]    prod_q2;
    logic [W_P2+W_H2-1:0]    prod_pp;
    logic [W_Q2+W_H2-1:0]    prod_qq;
    logic [W_HM+W_P-1:0]     prod_num;
    logic [W_SD-1+W_M-1:0]   prod_seed;
    logic [W_SD-1:0]         seed_full;
    logic [W_NUM+W_Y-1:0]    prod_tm;
    logic [W_NUM+W_Y-QF-1:0] tm_full;
    logic [QF:0]             tm;
    logic [W_T-1:0]          sig_sum;
    logic [W_SAMPLE+W_SIG-1:0] prod_out;
    logic [W_SAMPLE:0]       out_mag;
    logic [W_SAMPLE-1:0]     x_raw;

    // stage advance: a stage moves when the receiver takes a word or when
    // some stage at or after it is empty
    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            adv[k] = i_out_ready || ((~r_vld & (STG_ALL << k)) != '0);
        end
    end

    // valid bits follow their words
    assign vld_src = {r_vld[NSTG-2:0], i_in_valid};

    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            n_vld[k] = adv[k] ? vld_src[k] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // stage 0: magnitude, saturation check, h = x/2 in Q.30
    always_comb begin
        x_raw         = i_in_word.sample_in;
        n_s0.side.last = i_in_word.last_sample;
        n_s0.side.neg  = x_raw[W_SAMPLE-1];
        n_s0.side.ax   = x_raw[W_SAMPLE-1] ? (~x_raw + 1'b1) : x_raw;
        n_s0.side.sat  = (n_s0.side.ax >= SAT_X);
        n_s0.hm        = n_s0.side.sat ? '0 : (W_HM'(n_s0.side.ax) << H_SHIFT);
    end

    // stage 1: h^2
    always_comb begin
        prod_h2   = r_s0.hm * r_s0.hm;
        n_s1.side = r_s0.side;
        n_s1.hm   = r_s0.hm;
        n_s1.h2   = prod_h2[QF +: W_H2];
    end

    // stage 2: first horner step of both polynomials
    always_comb begin
        prod_p1   = CP3 * r_s1.h2;
        prod_q1   = CQ3 * r_s1.h2;
        n_s2.side = r_s1.side;
        n_s2.hm   = r_s1.hm;
        n_s2.h2   = r_s1.h2;
        n_s2.p1   = prod_p1[QF +: W_P1] + W_P1'(CP2);
        n_s2.q1   = prod_q1[QF +: W_Q1] + W_Q1'(CQ2);
    end

    // stage 3: second horner step
    always_comb begin
        prod_p2   = r_s2.p1 * r_s2.h2;
        prod_q2   = r_s2.q1 * r_s2.h2;
        n_s3.side = r_s2.side;
        n_s3.hm   = r_s2.hm;
        n_s3.h2   = r_s2.h2;
        n_s3.p2   = prod_p2[QF +: W_P2] + W_P2'(CP1);
        n_s3.q2   = prod_q2[QF +: W_Q2] + W_Q2'(CQ1);
    end

    // stage 4: last horner step, P and Q complete
    always_comb begin
        prod_pp   = r_s3.p2 * r_s3.h2;
        prod_qq   = r_s3.q2 * r_s3.h2;
        n_s4.side = r_s3.side;
        n_s4.hm   = r_s3.hm;
        n_s4.pp   = prod_pp[QF +: W_P] + W_P'(Q30_ONE);
        n_s4.qq   = prod_qq[QF +: W_Q] + W_Q'(Q30_ONE);
    end

    // stage 5: numerator h*P, leading one of Q and normalized mantissa
    always_comb begin
        prod_num  = r_s4.hm * r_s4.pp;
        n_s5.side = r_s4.side;
        n_s5.num  = prod_num[QF +: W_NUM];
        n_s5.qq   = r_s4.qq;
        n_s5.sh   = '0;
        for (int b = QF; b < W_Q; b++) begin
            if (r_s4.qq[b]) begin
                n_s5.sh = W_S'(b - QF + 1);
            end
        end
        n_s5.m = W_M'(r_s4.qq >> n_s5.sh);
    end

    // stage 6: linear reciprocal seed, scaled back by the same shift
    always_comb begin
        prod_seed  = SEED_B * r_s5.m;
        seed_full  = SEED_A - W_SD'(prod_seed[QF +: W_SD-1]);
        n_rc0.side = r_s5.side;
        n_rc0.num  = r_s5.num;
        n_rc0.qq   = r_s5.qq;
        n_rc0.y    = W_Y'(seed_full >> r_s5.sh);
    end

    // newton refinement, two stages per step: t = 2 - Q*y, then y = y*t
    for (genvar j = 0; j < NEWTON_STEPS; j++) begin : g_newton
        logic [W_Q+W_Y-1:0] prod_e;
        logic [W_Y+W_T-1:0] prod_y;
        t_rcp               n_rc;

        assign prod_e = r_rc[j].qq * r_rc[j].y;
        assign prod_y = r_na[j].y * r_nt[j];

        always_comb begin
            n_rc   = r_na[j];
            n_rc.y = prod_y[QF +: W_Y];
        end

        always_ff @(posedge i_clk) begin
            if (adv[ST_RC0+1+2*j]) begin
                r_na[j] <= r_rc[j];
                r_nt[j] <= Q30_TWO - prod_e[QF +: W_T];
            end
            if (adv[ST_RC0+2+2*j]) begin
                r_rc[j+1] <= n_rc;
            end
        end
    end

    // tanh = num * (1/Q), clamped, then sigmoid = (1 + tanh) / 2
    always_comb begin
        prod_tm = r_rc[NEWTON_STEPS].num * r_rc[NEWTON_STEPS].y;
        tm_full = prod_tm[W_NUM+W_Y-1:QF];
        if (r_rc[NEWTON_STEPS].side.sat || (tm_full > (W_NUM+W_Y-QF)'(Q30_ONE))) begin
            tm = Q30_ONE;
        end else begin
            tm = tm_full[QF:0];
        end
        if (r_rc[NEWTON_STEPS].side.neg) begin
            sig_sum = W_T'(Q30_ONE) - W_T'(tm);
        end else begin
            sig_sum = W_T'(Q30_ONE) + W_T'(tm);
        end
        n_tn.last = r_rc[NEWTON_STEPS].side.last;
        n_tn.neg  = r_rc[NEWTON_STEPS].side.neg;
        n_tn.ax   = r_rc[NEWTON_STEPS].side.ax;
        n_tn.sig  = sig_sum[W_T-1:1];
    end

    // output: x * sigmoid, truncated toward zero
    always_comb begin
        prod_out       = r_tn.ax * r_tn.sig;
        out_mag        = prod_out[QF +: W_SAMPLE+1];
        n_out.silu_out = $signed(W_SAMPLE'(r_tn.neg ? (~out_mag + 1'b1) : out_mag));
        n_out.last_out = r_tn.last;
    end

    // stage registers, payload only
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s0 <= n_s0;
        end
        if (adv[1]) begin
            r_s1 <= n_s1;
        end
        if (adv[2]) begin
            r_s2 <= n_s2;
        end
        if (adv[3]) begin
            r_s3 <= n_s3;
        end
        if (adv[4]) begin
            r_s4 <= n_s4;
        end
        if (adv[5]) begin
            r_s5 <= n_s5;
        end
        if (adv[ST_RC0]) begin
            r_rc[0] <= n_rc0;
        end
        if (adv[ST_TANH]) begin
            r_tn <= n_tn;
        end
        if (adv[ST_OUT]) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = adv[0];
    assign o_out_valid = r_vld[ST_OUT];
    assign o_out_word  = r_out;

    // an empty stage anywhere must let a new word in
    a_bubble_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld != STG_ALL) |-> o_in_ready)
        else $error("input stalled while a pipeline stage is empty");

    // denominator is at least one: normalizing shift is nonzero and at most SH_MAX
    a_norm_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> (r_s5.sh != '0) && (r_s5.sh <= W_S'(SH_MAX)))
        else $error("denominator normalizing shift out of range");

    // refined reciprocal lies in (0, 1]
    a_recip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_RC0+2*NEWTON_STEPS] |->
            (r_rc[NEWTON_STEPS].y != '0) && (r_rc[NEWTON_STEPS].y <= W_Y'(Q30_ONE)))
        else $error("reciprocal outside (0, 1]");

    // sigmoid never exceeds one
    a_sig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_TANH] |-> (r_tn.sig <= W_SIG'(Q30_ONE)))
        else $error("sigmoid above one");

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the SiLU rational tanh pipeline: drives signed Q16.16 sample
// words in bursts, stalls the result side on its own pattern, and compares
// every result word against a bit-exact Q.30 prediction of x * sigmoid(x).
// ----------------------------------------------------------------------------
module tb
    import silu_rt_pkg::*;
();

    localparam int RANDOM_WORDS = 500;
    localparam int HOLD_CYCLES  = 80;     // long receiver hold-off
    localparam int DRAIN_CYCLES = 40;     // settle time after the last result
    localparam int IDLE_LIMIT   = 2000;   // watchdog, cycles with no transfer
    localparam int SAT_SAMPLE   = 32'h000C_0000;  // 12.0, where |h| reaches 6

    // ------------------------------------------------------------------------
    // expected result store with a bit-exact Q.30 predictor
    // ------------------------------------------------------------------------
    class silu_scoreboard;
        localparam int     FRAC    = 16;
        localparam int     NR_ITER = 2;
        localparam longint ONE     = 64'sd1 << 30;
        localparam longint HSAT    = 64'sd6 << 30;
        localparam longint KP1     = 64'sd137659208;
        localparam longint KP2     = 64'sd3003474;
        localparam longint KP3     = 64'sd7946;
        localparam longint KQ1     = 64'sd495573150;
        localparam longint KQ2     = 64'sd25028947;
        localparam longint KQ3     = 64'sd222479;
        localparam longint SEED_C0 = 64'sd3031741621;
        localparam longint SEED_C1 = 64'sd2021161080;

        t_out_word   expect_q[$];
        int unsigned n_samples, n_results, n_errors, n_sat, n_neg, n_last;

        // magnitude product shifted by 30, sign restored, so it truncates toward zero
        function longint q30_mul(longint a, longint b);
            bit                neg;
            longint unsigned   ua, ub, ah, al, bh, bl, r;
            neg = (a < 0) != (b < 0);
            ua  = (a < 0) ? -a : a;
            ub  = (b < 0) ? -b : b;
            ah  = ua >> 30;
            al  = ua & 64'h3FFF_FFFF;
            bh  = ub >> 30;
            bl  = ub & 64'h3FFF_FFFF;
            r   = ((ah * bh) << 30) + ah * bl + al * bh + ((al * bl) >> 30);
            return neg ? -$signed(r) : $signed(r);
        endfunction

        // cubic in h^2 with unit constant term
        function longint poly_h2(longint c3, longint c2, longint c1, longint h2);
            longint p;
            p = c3;
            p = q30_mul(p, h2) + c2;
            p = q30_mul(p, h2) + c1;
            p = q30_mul(p, h2) + ONE;
            return p;
        endfunction

        // seeded reciprocal of the denominator with newton refinement
        function longint den_recip(longint den);
            int     k;
            int     s;
            longint m, y;
            k = 62;
            while (k > 0 && den[k] == 1'b0)
                k--;
            s = (k >= 30) ? (k - 29) : 0;
            m = $unsigned(den) >> s;
            y = SEED_C0 - q30_mul(SEED_C1, m);
            y = $unsigned(y) >> s;
            for (int i = 0; i < NR_ITER; i++)
                y = q30_mul(y, 2 * ONE - q30_mul(den, y));
            return y;
        endfunction

        function longint tanh_q30(longint h);
            longint mag, h2, num, den, t;
            mag = (h < 0) ? -h : h;
            if (mag >= HSAT)
                return (h < 0) ? -ONE : ONE;
            h2  = q30_mul(h, h);
            num = q30_mul(h, poly_h2(KP3, KP2, KP1, h2));
            den = poly_h2(KQ3, KQ2, KQ1, h2);
            t   = q30_mul(num, den_recip(den));
            if (t > ONE)
                t = ONE;
            if (t < -ONE)
                t = -ONE;
            return t;
        endfunction

        function t_out_word silu_of(t_in_word w);
            t_out_word r;
            longint    x, xq, h, sig, y;
            x   = w.sample_in;
            xq  = x * (64'sd1 << (30 - FRAC));
            h   = (xq < 0) ? -((-xq) >>> 1) : (xq >>> 1);
            sig = $unsigned(ONE + tanh_q30(h)) >> 1;
            y   = q30_mul(x, sig);
            r.silu_out = y[31:0];
            r.last_out = w.last_sample;
            return r;
        endfunction

        function void note_sample(t_in_word w);
            longint x;
            x = w.sample_in;
            n_samples++;
            if (x >= SAT_SAMPLE || x <= -SAT_SAMPLE)
                n_sat++;
            if (x < 0)
                n_neg++;
            if (w.last_sample)
                n_last++;
            expect_q.push_back(silu_of(w));
        endfunction

        function void check_result(t_out_word got);
            t_out_word exp_w;
            n_results++;
            if (expect_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result word: silu %0d last %0b",
                             got.silu_out, got.last_out);
                return;
            end
            exp_w = expect_q.pop_front();
            if (got.silu_out !== exp_w.silu_out || got.last_out !== exp_w.last_out) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("result %0d mismatch: silu exp %h got %h, last exp %0b got %0b",
                             n_results, exp_w.silu_out, got.silu_out,
                             exp_w.last_out, got.last_out);
            end
        endfunction

        function int pending();
            return expect_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block under test
    // ------------------------------------------------------------------------
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_word;

    silu_scoreboard sb = new();
    int             idle_cycles   = 0;
    int             hold_requests = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    silu_rational_tanh DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // ------------------------------------------------------------------------
    // transfer monitor, sampled mid-cycle where both sides are settled
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_in_valid === 1'b1 && o_in_ready === 1'b1)
                sb.note_sample(i_in_word);
            if (o_out_valid === 1'b1 && i_out_ready === 1'b1)
                sb.check_result(o_out_word);
            if ((i_in_valid === 1'b1 && o_in_ready === 1'b1) ||
                (o_out_valid === 1'b1 && i_out_ready === 1'b1))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog on cycles with no word moving
    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(negedge i_clk);
        $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, sb.pending());
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: stall modes that change at random, plus requested hold-offs
    // ------------------------------------------------------------------------
    initial begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        int served;
        int cyc;
        bit rdy;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        served    = 0;
        cyc       = 0;
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            if (served != hold_requests) begin
                served    = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0: rdy = 1'b1;
                    1: rdy = ($urandom_range(0, 3) != 0);
                    2: rdy = ($urandom_range(0, 9) < 3);
                    default: rdy = (cyc % 5 != 4);
                endcase
            end
            i_out_ready <= rdy;
            cyc++;
            @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // sender tasks
    // ------------------------------------------------------------------------
    // offer one word and hold it until taken
    task automatic send_sample(input logic [31:0] value, input bit last);
        bit taken;
        i_in_word.sample_in   <= value;
        i_in_word.last_sample <= last;
        i_in_valid            <= 1'b1;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = (o_in_ready === 1'b1);
            @(posedge i_clk);
        end
    endtask

    task automatic sender_gap(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // stop offering until every expected word is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.pending() != 0);
    endtask

    // mixed magnitudes: mostly the curved region, some near saturation, some raw
    function automatic logic [31:0] rand_sample();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom_range(0, 32'h001C_0000) - 32'h000E_0000;
            5: begin
                v = SAT_SAMPLE + $urandom_range(0, 127) - 64;
                if ($urandom_range(0, 1))
                    v = -v;
            end
            6: v = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] corner[$];
        int          burst_left;
        int          gap;
        corner = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
                   32'hFFFF_8000, 32'h0002_0000, 32'hFFFE_0000, 32'h0005_0000,
                   32'hFFFB_0000, 32'h000B_E666, 32'hFFF4_199A, 32'h000B_FFFF,
                   32'hFFF4_0001, 32'h000C_0000, 32'hFFF4_0000, 32'h0064_0000,
                   32'hFF9C_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, unit values, both sides of the saturation edge
        foreach (corner[i])
            send_sample(corner[i], (i % 3 == 2));
        wait_drained();

        // random bursts with a long receiver hold-off and one full drain
        burst_left = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 150)
                hold_requests++;
            if (n == 320)
                wait_drained();
            send_sample(rand_sample(), ($urandom_range(0, 7) == 0));
            if (n >= 150 && n < 240)
                continue;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 48);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                    sender_gap(gap);
            end else begin
                burst_left--;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d samples: %0d past the tanh saturation edge, %0d negative, %0d last",
                 sb.n_samples, sb.n_sat, sb.n_neg, sb.n_last);
        $display("checked %0d result words under bursty input and receiver stalls, %0d errors",
                 sb.n_results, sb.n_errors);
        if (sb.n_errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
sv/silu_rt_pkg.sv
sv/silu_rational_tanh.sv
bench/tb.sv
